### hdl/tilt_compensated_heading_macros.svh
// assertion macros for the tilt compensated heading block
// no dependencies
`ifndef TILT_COMPENSATED_HEADING_MACROS_SVH
`define TILT_COMPENSATED_HEADING_MACROS_SVH
// implication checked on every clock, held off in reset
`define TCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define TCH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### hdl/tch_pkg.sv
// shared types and constants for the tilt compensated heading block
// no dependencies
`default_nettype none
package tch_pkg;
  localparam int unsigned AngLen = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0] Turn = 32'd36000;

  typedef enum logic [2:0] {
    REG_OFF_X = 3'd0, REG_OFF_Y = 3'd1, REG_OFF_Z = 3'd2,
    REG_SCL_X = 3'd3, REG_SCL_Y = 3'd4, REG_SCL_Z = 3'd5,
    REG_DECL = 3'd6, REG_NONE = 3'd7
  } reg_idx_t;

  // cordic unit command and status
  typedef struct packed {
    logic start;
    logic vect;
    logic [31:0] theta;
    logic signed [33:0] x0;
    logic signed [33:0] y0;
  } cor_cmd_t;

  typedef struct packed {
    logic done;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic [31:0] z;
  } cor_sts_t;

  function automatic logic [31:0] ang_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912; 5'd1: r = 32'd316933406; 5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;  5'd4: r = 32'd42667331;  5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;  5'd7: r = 32'd5340245;   5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;   5'd10: r = 32'd667544;   5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;   5'd13: r = 32'd83443;    5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;    5'd16: r = 32'd10430;    5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;     5'd19: r = 32'd1304;     5'd20: r = 32'd652;
      5'd21: r = 32'd326;      5'd22: r = 32'd163;      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### hdl/tch_cordic.sv
// shared iterative cordic, rotation (sine/cosine) and vectoring (atan2)
// depends on tch_pkg
`default_nettype none
module tch_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tch_pkg::cor_cmd_t cmd,
  output tch_pkg::cor_sts_t     sts
);
  import tch_pkg::*;

  logic signed [33:0] x_r, y_r, x_nxt, y_nxt;
  logic [31:0] z_r, z_nxt;
  logic [4:0] i_r;
  logic busy_r, vect_r, done_r;
  logic dir;
  logic last_c;
  logic signed [33:0] xs, ys;

  // one micro-rotation a cycle
  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    dir = vect_r ? !y_r[33] : !z_r[31];
    if (dir != vect_r) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
    end
    z_nxt = (dir == vect_r) ? z_r + ang_lut(i_r) : z_r - ang_lut(i_r);
    last_c = ({27'd0, i_r} == STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      vect_r <= cmd.vect;
      i_r <= '0;
      x_r <= cmd.x0;
      y_r <= cmd.y0;
      z_r <= cmd.theta;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      i_r <= i_r + 5'd1;
      busy_r <= !last_c;
      done_r <= last_c;
    end else begin
      done_r <= 1'b0;
    end
  end

  assign sts = '{done: done_r, x: x_r, y: y_r, z: z_r};
endmodule
`default_nettype wire

### hdl/tilt_compensated_heading.sv
// top level: calibration, tilt rotation, atan2, declination and heading filter
// depends on tch_pkg, tch_cordic and the macros header
//
// channel  direction  handshake     payload
// in_      input      valid/stall   mag_x/y/z, roll_angle, pitch_angle
// out_     output     valid/stall   heading
// cfg_     input      valid/ready   index, data
//
// accept to out_valid runs two rotation passes and one vectoring pass in the shared cordic
// plus the sequencer states; a new sample is taken once the sequencer is back in idle.
// a zero horizontal field skips the atan2 pass, the first sample skips the filter step.
// synchronous reset clears the sequencer and filter state and loads the register defaults.
// a held result stalls only the output state; input is refused while the sequencer runs.
`default_nettype none
`include "tilt_compensated_heading_macros.svh"
module tilt_compensated_heading #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_mag_x,
  input  wire logic signed [15:0] in_mag_y,
  input  wire logic signed [15:0] in_mag_z,
  input  wire logic signed [15:0] in_roll_angle,
  input  wire logic signed [15:0] in_pitch_angle,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_heading,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);
  import tch_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CAL, S_BANG, S_ROLL, S_WROLL, S_PITCH, S_WPITCH,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_ATAN, S_WATAN,
    S_HDEG, S_DECL, S_FILT, S_FMUL, S_OUT
  } state_t;

  state_t st_r;
  logic signed [16:0] off_r [3];
  logic [15:0] scl_r [3];
  logic signed [15:0] decl_r;
  logic [31:0] filt_r;
  logic hv_r;
  logic signed [15:0] mag_r [3];
  logic signed [15:0] ang_r [2];
  logic [1:0] k_r;
  logic signed [33:0] cal_r [3];
  logic [31:0] bang_r [2];
  logic signed [33:0] sr_r, cr_r, sp_r, cp_r;
  logic signed [63:0] acc_r, t_r;
  logic signed [33:0] xh_r, yh_r;
  logic [31:0] zb_r;
  logic signed [31:0] h_r;
  logic out_valid_r;
  logic [15:0] out_r;
  cor_cmd_t cmd;
  cor_sts_t sts;

  tch_cordic #(.STEPS(CORDIC_STEPS)) u_cor (.clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts));

  assign cfg_ready = (st_r == S_IDLE);
  assign in_stall = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_heading = out_r;

  // floor shift helper on 64-bit values is plain arithmetic shift
  logic signed [33:0] d_c;
  logic signed [51:0] p_c;
  logic signed [15:0] a_c;
  logic [15:0] abs_c;
  logic [32:0] qi_c;
  logic [41:0] qf_c;
  logic [31:0] qb_c;
  logic [31:0] bang_c;
  logic [31:0] th_c;
  logic neg_c;
  always_comb begin
    d_c = 34'(2 * 34'(mag_r[k_r])) - 34'(off_r[k_r]);
    p_c = d_c * $signed({1'b0, scl_r[k_r]});
    if (k_r == 2'd2) p_c = -p_c;
    // centidegrees to binary angle, truncated toward zero:
    // 2^32/36000 = 119304 + 728/1125, the fraction by reciprocal multiply
    a_c = ang_r[k_r[0]];
    abs_c = a_c[15] ? 16'(-a_c) : 16'(a_c);
    qi_c = 33'(abs_c) * 33'd119304;
    qf_c = 42'(abs_c) * 42'd43426892;
    qb_c = qi_c[31:0] + 32'(qf_c >> 26);
    bang_c = a_c[15] ? -qb_c : qb_c;
    th_c = (st_r == S_ROLL || st_r == S_WROLL) ? bang_r[0] : bang_r[1];
    neg_c = th_c[31] ^ th_c[30];
  end

  logic signed [63:0] dv_c, f_c;
  logic signed [31:0] hq_c;
  logic [47:0] hm_c;
  always_comb begin
    hm_c = zb_r * 16'd36000 + 48'h8000_0000;
    hq_c = 32'(hm_c[47:32]);
    dv_c = 64'(h_r) * 256 - $signed(64'(filt_r));
    if (dv_c > 64'sd4608000) dv_c = dv_c - 64'sd9216000;
    else if (dv_c < -64'sd4608000) dv_c = dv_c + 64'sd9216000;
    f_c = $signed(64'(filt_r)) + (t_r >>> 16);
  end

  always_comb begin
    cmd = '0;
    cmd.x0 = CordicGain;
    case (st_r)
      S_ROLL, S_PITCH: begin
        cmd.start = 1'b1;
        cmd.theta = neg_c ? th_c + 32'h8000_0000 : th_c;
      end
      S_ATAN: begin
        cmd.start = !(xh_r == 0 && yh_r == 0);
        cmd.vect = 1'b1;
        cmd.x0 = xh_r[33] ? -xh_r : xh_r;
        cmd.y0 = xh_r[33] ? -yh_r : yh_r;
        cmd.theta = xh_r[33] ? 32'h8000_0000 : 32'd0;
      end
      default: cmd.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      off_r[0] <= '0; off_r[1] <= '0; off_r[2] <= '0;
      scl_r[0] <= 16'd16384; scl_r[1] <= 16'd16384; scl_r[2] <= 16'd16384;
      decl_r <= -16'sd100;
      filt_r <= '0;
      hv_r <= 1'b0;
      out_valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      // result beat: load from the output state, clear on accept
      if (st_r == S_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          // register writes
          if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
              REG_OFF_X: off_r[0] <= cfg_data;
              REG_OFF_Y: off_r[1] <= cfg_data;
              REG_OFF_Z: off_r[2] <= cfg_data;
              REG_SCL_X: scl_r[0] <= cfg_data[15:0];
              REG_SCL_Y: scl_r[1] <= cfg_data[15:0];
              REG_SCL_Z: scl_r[2] <= cfg_data[15:0];
              REG_DECL:  decl_r <= cfg_data[15:0];
              default: ;
            endcase
          end
          if (in_valid && !in_stall) begin
            mag_r[0] <= in_mag_x; mag_r[1] <= in_mag_y; mag_r[2] <= in_mag_z;
            ang_r[0] <= in_roll_angle; ang_r[1] <= in_pitch_angle;
            k_r <= '0;
            st_r <= S_CAL;
          end
        end
        // one axis per cycle through the calibration multiplier
        S_CAL: begin
          cal_r[k_r] <= 34'(p_c >>> 14);
          if (k_r == 2'd2) begin
            k_r <= '0;
            st_r <= S_BANG;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_BANG: begin
          bang_r[k_r[0]] <= bang_c;
          k_r <= k_r + 2'd1;
          if (k_r[0]) st_r <= S_ROLL;
        end
        S_ROLL: st_r <= S_WROLL;
        S_WROLL: if (sts.done) begin
          sr_r <= neg_c ? -sts.y : sts.y;
          cr_r <= neg_c ? -sts.x : sts.x;
          st_r <= S_PITCH;
        end
        S_PITCH: st_r <= S_WPITCH;
        S_WPITCH: if (sts.done) begin
          sp_r <= neg_c ? -sts.y : sts.y;
          cp_r <= neg_c ? -sts.x : sts.x;
          st_r <= S_M1;
        end
        // horizontal field, products accumulated over the states S_M1 to S_M7
        S_M1: begin acc_r <= cal_r[0] * cp_r; st_r <= S_M2; end
        S_M2: begin
          xh_r <= 34'((acc_r + cal_r[2] * sp_r) >>> 22);
          t_r <= (sr_r * sp_r) >>> 30;
          st_r <= S_M3;
        end
        S_M3: begin acc_r <= cal_r[0] * 34'(t_r); st_r <= S_M4; end
        S_M4: begin acc_r <= acc_r + cal_r[1] * cr_r; st_r <= S_M5; end
        S_M5: begin t_r <= (sr_r * cp_r) >>> 30; st_r <= S_M6; end
        S_M6: begin acc_r <= acc_r - cal_r[2] * 34'(t_r); st_r <= S_M7; end
        S_M7: begin yh_r <= 34'(acc_r >>> 22); st_r <= S_ATAN; end
        S_ATAN: begin
          zb_r <= 32'd0;
          st_r <= (xh_r == 0 && yh_r == 0) ? S_HDEG : S_WATAN;
        end
        S_WATAN: if (sts.done) begin zb_r <= sts.z; st_r <= S_HDEG; end
        S_HDEG: begin
          h_r <= (hq_c >= 32'sd36000) ? hq_c - 32'sd36000 : hq_c;
          st_r <= S_DECL;
        end
        S_DECL: begin
          if (h_r + 32'(decl_r) < 0) h_r <= h_r + 32'(decl_r) + 32'sd36000;
          else if (h_r + 32'(decl_r) >= 32'sd36000)
            h_r <= h_r + 32'(decl_r) - 32'sd36000;
          else h_r <= h_r + 32'(decl_r);
          st_r <= S_FILT;
        end
        S_FILT: begin
          if (!hv_r) begin
            filt_r <= 32'(h_r) << 8;
            hv_r <= 1'b1;
            st_r <= S_OUT;
          end else begin
            t_r <= dv_c * 64'sd19661 + 64'sd32768;
            st_r <= S_FMUL;
          end
        end
        S_FMUL: begin
          if (f_c >= 64'sd9216000) filt_r <= 32'(f_c - 64'sd9216000);
          else if (f_c < 0) filt_r <= 32'(f_c + 64'sd9216000);
          else filt_r <= 32'(f_c);
          st_r <= S_OUT;
        end
        // wait here while the previous beat is still held
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            if ((filt_r + 32'd128) >> 8 >= Turn)
              out_r <= 16'(((filt_r + 32'd128) >> 8) - Turn);
            else out_r <= 16'((filt_r + 32'd128) >> 8);
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `TCH_ASSERT_IMP(a_out_range, out_valid, out_heading < 16'd36000)
  `TCH_ASSERT_IMP(a_filt_range, 1'b1, filt_r < 32'd9216000)
  `TCH_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall)
endmodule
`default_nettype wire

### test/tb_tilt_compensated_heading.sv
// testbench for the tilt compensated heading block: directed and random samples,
// checked beat by beat against a behavioural heading predictor; depends on tch_pkg
`timescale 1ns / 100ps
`default_nettype none
module tb_tilt_compensated_heading;
  import tch_pkg::*;

  localparam int unsigned Steps = 16;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  wire logic in_stall;
  logic signed [15:0] in_mag_x = '0, in_mag_y = '0, in_mag_z = '0;
  logic signed [15:0] in_roll_angle = '0, in_pitch_angle = '0;
  wire logic out_valid;
  logic out_stall = 1'b0;
  wire logic [15:0] out_heading;
  logic cfg_valid = 1'b0;
  wire logic cfg_ready;
  logic [2:0] cfg_index = REG_NONE;
  logic [16:0] cfg_data = '0;

  tilt_compensated_heading #(.CORDIC_STEPS(Steps)) u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_mag_x, .in_mag_y, .in_mag_z,
    .in_roll_angle, .in_pitch_angle, .out_valid, .out_stall, .out_heading,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state and register copy
  longint m_off[3];
  longint m_scl[3];
  longint m_decl;
  longint m_filt;
  bit m_init;

  sample_t pending[$];
  logic [15:0] want_heading[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  int idle_cycles = 0;
  int beats_out = 0;
  // input beat taken at the last rising edge
  bit in_took = 1'b0;

  function automatic longint fl_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint cdeg_bang(longint a);
    longint q;
    q = (a * 64'sd4294967296) / 36000;
    return q & 64'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] ang_tab(int i);
    logic [31:0] t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic void rot_sin_cos(input longint th, output longint s,
                                      output longint c);
    longint x, y, z, nx;
    logic [31:0] t;
    bit neg;
    t = th[31:0];
    neg = 0;
    if (((t + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      t = t + 32'h8000_0000;
      neg = 1;
    end
    z = longint'(signed'(t));
    x = 652032874;
    y = 0;
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= longint'(ang_tab(i));
      end else begin
        nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += longint'(ang_tab(i));
      end
      x = nx;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function automatic logic [31:0] vec_atan2(longint y, longint x);
    logic [31:0] z;
    longint nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += ang_tab(i);
      end else begin
        nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= ang_tab(i);
      end
      x = nx;
    end
    return z;
  endfunction

  // heading for one sample, advancing the filter copy
  function automatic logic [15:0] next_heading(sample_t s);
    longint xc, yc, zc, sr, cr, sp, cp, xh, yh, h, f, d, o;
    logic [31:0] zb;
    xc = fl_shr((2 * longint'(s.mx) - m_off[0]) * m_scl[0], 14);
    yc = fl_shr((2 * longint'(s.my) - m_off[1]) * m_scl[1], 14);
    zc = fl_shr(-((2 * longint'(s.mz) - m_off[2]) * m_scl[2]), 14);
    rot_sin_cos(cdeg_bang(longint'(s.roll)), sr, cr);
    rot_sin_cos(cdeg_bang(longint'(s.pitch)), sp, cp);
    xh = fl_shr(xc * cp + zc * sp, 22);
    yh = fl_shr(xc * fl_shr(sr * sp, 30) + yc * cr - zc * fl_shr(sr * cp, 30), 22);
    zb = vec_atan2(yh, xh);
    h = longint'((64'(zb) * 36000 + 64'h8000_0000) >> 32);
    if (h >= 36000) h -= 36000;
    h += m_decl;
    if (h < 0) h += 36000;
    else if (h >= 36000) h -= 36000;
    if (!m_init) begin
      f = h * 256;
      m_init = 1;
    end else begin
      f = m_filt;
      d = h * 256 - f;
      if (d > 18000 * 256) d -= 36000 * 256;
      else if (d < -18000 * 256) d += 36000 * 256;
      f += fl_shr(d * 19661 + 32768, 16);
      if (f >= 36000 * 256) f -= 36000 * 256;
      if (f < 0) f += 36000 * 256;
    end
    m_filt = f;
    o = (f + 128) >>> 8;
    if (o >= 36000) o -= 36000;
    return o[15:0];
  endfunction

  // driver: one beat per accept, payload held while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (in_valid) void'(pending.pop_front());
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          {in_mag_x, in_mag_y, in_mag_z, in_roll_angle, in_pitch_angle} <= pending[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall)
        want_heading.push_back(next_heading(
          {in_mag_x, in_mag_y, in_mag_z, in_roll_angle, in_pitch_angle}));
      if (out_valid && !out_stall) begin
        beats_out <= beats_out + 1;
        if (want_heading.size() == 0) begin
          $error("heading beat with nothing expected: actual %0d", out_heading);
          errors++;
        end else begin
          logic [15:0] w;
          w = want_heading.pop_front();
          if (w !== out_heading) begin
            $error("heading: expected %0d actual %0d", w, out_heading);
            errors++;
          end
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no beat for %0d cycles", WatchLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OFF_X, REG_OFF_Y, REG_OFF_Z: m_off[idx] = longint'(signed'(val));
      REG_SCL_X, REG_SCL_Y, REG_SCL_Z: m_scl[idx - 3] = longint'(val[15:0]);
      REG_DECL: m_decl = longint'(signed'(val[15:0]));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || want_heading.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    return (($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(36000)) - 18000));
  endfunction

  task automatic add_random(int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      s.mx = 16'($urandom); s.my = 16'($urandom); s.mz = 16'($urandom);
      if ($urandom_range(4) == 0) begin
        s.mx = 16'($urandom_range(40)) - 16'sd20;
        s.my = 16'($urandom_range(40)) - 16'sd20;
      end
      s.roll = rand_angle();
      s.pitch = rand_angle();
      pending.push_back(s);
    end
  endtask

  task automatic rand_regs();
    for (int k = 0; k < 3; k++)
      write_reg(reg_idx_t'(k), 17'($urandom));
    for (int k = 3; k < 6; k++)
      write_reg(reg_idx_t'(k), 17'($urandom_range(32767)));
    write_reg(REG_DECL, 17'(int'($urandom_range(36000)) - 18000));
  endtask

  initial begin
    m_off = '{0, 0, 0};
    m_scl = '{16384, 16384, 16384};
    m_decl = -100;
    m_filt = 0;
    m_init = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, extremes, zero field, wrapping angles
    send_idle = 0; recv_idle = 0;
    pending.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd18000, 16'sd18000});
    pending.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending.push_back('{16'sd100, -16'sd100, 16'sd50, 16'sd32767, -16'sd32768});
    pending.push_back('{-16'sd1, 16'sd1, 16'sd0, 16'sd9000, -16'sd9000});
    pending.push_back('{16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd0});
    pending.push_back('{16'sd0, -16'sd1000, 16'sd0, 16'sd0, 16'sd0});
    pending.push_back('{-16'sd1000, 16'sd0, 16'sd0, 16'sd4500, 16'sd4500});
    drain();

    // register extremes, a zero scale, declination edges, ignored index
    write_reg(REG_OFF_X, 17'h0FFFF);
    write_reg(REG_OFF_Y, 17'h10000);
    write_reg(REG_OFF_Z, 17'h1FFFF);
    write_reg(REG_SCL_X, 17'h0FFFF);
    write_reg(REG_SCL_Y, 17'h00000);
    write_reg(REG_SCL_Z, 17'h08000);
    write_reg(REG_DECL, 17'(-18000));
    write_reg(REG_NONE, 17'h1FFFF);
    pending.push_back('{16'sd32767, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0});
    pending.push_back('{-16'sd32768, 16'sd5, 16'sd32767, 16'sd18000, 16'sd1});
    pending.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    drain();
    write_reg(REG_DECL, 17'd18000);
    write_reg(REG_SCL_Y, 17'd16384);
    pending.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending.push_back('{16'sd3, 16'sd200, -16'sd7, -16'sd1, 16'sd17999});
    drain();

    // random phases with changing idling
    send_idle = 12; recv_idle = 82;
    rand_regs();
    add_random(350);
    drain();
    send_idle = 82; recv_idle = 12;
    rand_regs();
    add_random(350);
    drain();
    send_idle = 0; recv_idle = 0;
    write_reg(REG_SCL_X, 17'd16384);
    write_reg(REG_SCL_Z, 17'd16384);
    add_random(350);
    drain();

    $display("ran %0d heading beats over directed and three random phases", beats_out);
    $display("register extremes, zero field and angle wrap were covered");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
